/* rtl/tksk_pkg.sv */
// Package for the top-k keep-best unit: mode codes, cell command and control types.
// No dependencies.
`default_nettype none
package tksk_pkg;

  localparam int VALUE_W     = 32;
  localparam int ID_PORT_W   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 72;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DRAIN  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  typedef enum logic [3:0] {
    CMD_HOLD   = 4'b0001,
    CMD_INSERT = 4'b0010,
    CMD_ROTATE = 4'b0100,
    CMD_CLEAR  = 4'b1000
  } cell_cmd_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_cmd_t                   cmd;
    logic                        accept;  // new value beats slot 0
    logic signed [VALUE_W-1:0]   value;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/tksk_cell.sv */
// One slot of the sorted chain: holds score, id and used bit.
// Depends on tksk_pkg.
`default_nettype none
module tksk_cell #(
  parameter int ID_WIDTH = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire  tksk_pkg::cell_ctl_t        ctl,
  input  wire         [ID_WIDTH-1:0]       id_in,
  input  wire                              up_lt,
  input  wire  signed [tksk_pkg::VALUE_W-1:0] up_score,
  input  wire         [ID_WIDTH-1:0]       up_ident,
  input  wire                              up_used,
  input  wire  signed [tksk_pkg::VALUE_W-1:0] lo_score,
  input  wire         [ID_WIDTH-1:0]       lo_ident,
  input  wire                              lo_used,
  output logic signed [tksk_pkg::VALUE_W-1:0] score,
  output logic        [ID_WIDTH-1:0]       ident,
  output logic                             used,
  output logic                             lt
);
  import tksk_pkg::*;

  assign lt = score < ctl.value;

  always_ff @(posedge clk) begin
    if (rst) begin
      score <= '0;
      ident <= '0;
      used  <= 1'b0;
    end else begin
      case (ctl.cmd)
        CMD_INSERT: begin
          if (ctl.accept) begin
            if (up_lt) begin
              score <= up_score;
              ident <= up_ident;
              used  <= up_used;
            end else if (lt) begin
              score <= ctl.value;
              ident <= id_in;
              used  <= 1'b1;
            end
          end
        end
        CMD_ROTATE: begin
          score <= lo_score;
          ident <= lo_ident;
          used  <= lo_used;
        end
        CMD_CLEAR: begin
          score <= '0;
          ident <= '0;
          used  <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/top_k_sorted_keep_best_unit.sv */
// Top level of the top-k keep-best unit: chain of tksk_cell slots, control and output register.
// Depends on tksk_pkg and tksk_cell.
//
//   channel  | dir | payload
//   s_axis   | in  | tuser[1:0] mode; tdata value[31:0], item_id[47:32]
//   m_axis   | out | tuser dropped_valid, entry_valid; tdata id/finish/entry; tlast last
//   cfg      | in  | cfg_we, cfg_wdata = finish_threshold
//
// Insert and clear: all cells compare and shift in parallel.
// Drain: the chain rotates once through all LIST_SIZE slots, then the closing transaction follows.
// A step waits while the output register holds an untaken transaction.
// rst (synchronous) zeroes every slot and sets the threshold to 0x7FFFFFFF.
`default_nettype none
module top_k_sorted_keep_best_unit #(
  parameter int LIST_SIZE = 16,
  parameter int ID_WIDTH  = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire  [31:0]                          cfg_wdata,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [tksk_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // value, item_id
  input  wire  [1:0]                           s_axis_tuser,  // mode
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // dropped_id, finish, entry_value, entry_id, zero fill
  output logic [tksk_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [1:0]                           m_axis_tuser,  // dropped_valid, entry_valid
  output logic                                 m_axis_tlast
);
  import tksk_pkg::*;

  localparam int RW = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
  localparam logic [RW-1:0] ROT_LAST = RW'(LIST_SIZE - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DRAIN = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state, state_next;

  logic signed [VALUE_W-1:0] thr;

  logic signed [VALUE_W-1:0] c_score [LIST_SIZE];
  logic        [ID_WIDTH-1:0] c_ident [LIST_SIZE];
  logic                       c_used  [LIST_SIZE];
  logic                       c_lt    [LIST_SIZE];

  cell_ctl_t                  ctl;
  logic        [ID_WIDTH-1:0] id_in;
  logic signed [VALUE_W-1:0]  in_value;
  logic [1:0]                 in_mode;
  logic                       fire, out_free, step, take;
  logic                       lt1;
  logic signed [VALUE_W-1:0]  score1, new0;

  logic [RW-1:0]              rot_cnt;
  logic [CNT_W-1:0]           n_out;
  logic                       pend_valid;
  logic signed [VALUE_W-1:0]  pend_score;
  logic        [ID_WIDTH-1:0] pend_ident;

  logic                       o_dv, o_fin, o_ev, o_last;
  logic [ID_PORT_W-1:0]       o_did, o_eid;
  logic signed [VALUE_W-1:0]  o_eval;

  assign in_value = s_axis_tdata[31:0];
  assign id_in    = ID_WIDTH'(s_axis_tdata[47:32]);
  assign in_mode  = s_axis_tuser;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign step          = (state == ST_DRAIN) && out_free;
  assign take          = c_used[LIST_SIZE-1] && (n_out < CNT_W'(MAX_RESULTS));

  always_comb begin
    ctl.value  = in_value;
    ctl.accept = c_lt[0];
    ctl.cmd    = CMD_HOLD;
    if (step) begin
      ctl.cmd = CMD_ROTATE;
    end else if (fire) begin
      case (in_mode)
        MODE_INSERT: ctl.cmd = CMD_INSERT;
        MODE_CLEAR:  ctl.cmd = CMD_CLEAR;
        default:     ctl.cmd = CMD_HOLD;
      endcase
    end
  end

  genvar k;
  generate
    for (k = 0; k < LIST_SIZE; k++) begin : g_cell
      logic                       up_lt, up_used, lo_used;
      logic signed [VALUE_W-1:0]  up_score, lo_score;
      logic        [ID_WIDTH-1:0] up_ident, lo_ident;

      if (k == LIST_SIZE - 1) begin : g_top
        assign up_lt    = 1'b0;
        assign up_score = '0;
        assign up_ident = '0;
        assign up_used  = 1'b0;
      end else begin : g_mid
        assign up_lt    = c_lt[k+1];
        assign up_score = c_score[k+1];
        assign up_ident = c_ident[k+1];
        assign up_used  = c_used[k+1];
      end

      if (k == 0) begin : g_wrap
        // entry leaving the top wraps to slot 0, marked unused once emitted
        assign lo_score = c_score[LIST_SIZE-1];
        assign lo_ident = c_ident[LIST_SIZE-1];
        assign lo_used  = c_used[LIST_SIZE-1] && !take;
      end else begin : g_link
        assign lo_score = c_score[k-1];
        assign lo_ident = c_ident[k-1];
        assign lo_used  = c_used[k-1];
      end

      tksk_cell #(.ID_WIDTH(ID_WIDTH)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .id_in    (id_in),
        .up_lt    (up_lt),
        .up_score (up_score),
        .up_ident (up_ident),
        .up_used  (up_used),
        .lo_score (lo_score),
        .lo_ident (lo_ident),
        .lo_used  (lo_used),
        .score    (c_score[k]),
        .ident    (c_ident[k]),
        .used     (c_used[k]),
        .lt       (c_lt[k])
      );
    end

    if (LIST_SIZE > 1) begin : g_n1
      assign lt1    = c_lt[1];
      assign score1 = c_score[1];
    end else begin : g_n1_none
      assign lt1    = 1'b0;
      assign score1 = '0;
    end
  endgenerate

  // slot 0 after an accepted insert
  assign new0 = lt1 ? score1 : in_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 32'sh7FFF_FFFF;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (fire && in_mode == MODE_DRAIN) state_next = ST_DRAIN;
      ST_DRAIN: if (step && rot_cnt == ROT_LAST) state_next = ST_FLUSH;
      ST_FLUSH: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rot_cnt    <= '0;
      n_out      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire && in_mode == MODE_DRAIN) begin
        rot_cnt    <= '0;
        n_out      <= '0;
        pend_valid <= 1'b0;
      end else if (step) begin
        rot_cnt <= rot_cnt + RW'(1);
        if (take) begin
          n_out      <= n_out + CNT_W'(1);
          pend_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && take) begin
      pend_score <= c_score[LIST_SIZE-1];
      pend_ident <= c_ident[LIST_SIZE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((fire && in_mode == MODE_INSERT) || (step && take && pend_valid)
                 || (state == ST_FLUSH && out_free)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_mode == MODE_INSERT) begin
      o_dv   <= c_lt[0] ? c_used[0] : 1'b1;
      o_did  <= c_lt[0] ? (c_used[0] ? ID_PORT_W'(c_ident[0]) : '0) : ID_PORT_W'(id_in);
      o_fin  <= c_lt[0] && (new0 > thr);
      o_ev   <= 1'b0;
      o_eval <= '0;
      o_eid  <= '0;
      o_last <= 1'b1;
    end else if ((step && take && pend_valid) || (state == ST_FLUSH && out_free)) begin
      o_dv   <= 1'b0;
      o_did  <= '0;
      o_fin  <= 1'b0;
      o_ev   <= pend_valid;
      o_eval <= pend_valid ? pend_score : '0;
      o_eid  <= pend_valid ? ID_PORT_W'(pend_ident) : '0;
      o_last <= (state == ST_FLUSH);
    end
  end

  assign m_axis_tdata = {7'd0, o_eid, o_eval, o_fin, o_did};
  assign m_axis_tuser = {o_ev, o_dv};
  assign m_axis_tlast = o_last;

endmodule
`default_nettype wire

/* rtl/tksk_checker.sv */
// Port-level checks for top_k_sorted_keep_best_unit, attached by bind.
// Depends on tksk_pkg.
`default_nettype none
module tksk_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [1:0]  s_axis_tuser,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [71:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser,
  input wire        m_axis_tlast
);
  import tksk_pkg::*;

  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output transaction changed");

  a_entry_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && !m_axis_tdata[16])
    else $error("drain transaction carries insert flags");

  a_insert_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_INSERT
      |=> m_axis_tvalid && m_axis_tlast && !m_axis_tuser[1])
    else $error("insert gave no single result");

  a_drain_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_DRAIN |=> !s_axis_tready)
    else $error("input taken while draining");

endmodule

bind top_k_sorted_keep_best_unit tksk_checker u_tksk_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

/* test/top_k_sorted_keep_best_checker.sv */
// Checker for top_k_sorted_keep_best_unit: watches the config port and both streams,
// keeps its own copy of the sorted keep-best list, and compares every output transaction.
// Depends on tksk_pkg.
module top_k_sorted_keep_best_checker #(
  parameter int LIST_SIZE = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [31:0]                      cfg_wdata,
  input  wire                              s_axis_tvalid,
  input  wire                              s_axis_tready,
  input  wire  [tksk_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // value, item_id
  input  wire  [1:0]                       s_axis_tuser,   // mode
  input  wire                              m_axis_tvalid,
  input  wire                              m_axis_tready,
  // dropped_id, finish, entry_value, entry_id, zero fill
  input  wire  [tksk_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  wire  [1:0]                       m_axis_tuser,   // dropped_valid, entry_valid
  input  wire                              m_axis_tlast,
  output int                               fail_count,
  output int                               pending,
  output int                               checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import tksk_pkg::*;

  typedef struct packed {
    logic                dropped_valid;
    logic [15:0]         dropped_id;
    logic                finish;
    logic                entry_valid;
    logic signed [31:0]  entry_value;
    logic [15:0]         entry_id;
    logic                last;
  } keep_result_t;

  logic signed [31:0] keep_score [LIST_SIZE];
  logic [15:0]        keep_ident [LIST_SIZE];
  logic               keep_used  [LIST_SIZE];
  logic signed [31:0] finish_limit;
  keep_result_t       awaited_results [$];
  int                 mismatches;
  int                 results_seen;

  function automatic keep_result_t make_result(input logic dv, input logic [15:0] did,
                                               input logic fin, input logic ev,
                                               input logic signed [31:0] evalue,
                                               input logic [15:0] eid, input logic last);
    keep_result_t r;
    r.dropped_valid = dv;
    r.dropped_id    = did;
    r.finish        = fin;
    r.entry_valid   = ev;
    r.entry_value   = evalue;
    r.entry_id      = eid;
    r.last          = last;
    return r;
  endfunction

  task automatic clear_slots();
    for (int i = 0; i < LIST_SIZE; i++) begin
      keep_score[i] = '0;
      keep_ident[i] = '0;
      keep_used[i]  = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic apply_keep_best(input logic [1:0] mode, input logic signed [31:0] val,
                                 input logic [15:0] id);
    int k;
    int held;
    int n;
    logic dv;
    logic [15:0] did;
    case (mode)
      MODE_INSERT: begin
        if (keep_score[0] < val) begin
          dv  = keep_used[0];
          did = keep_used[0] ? keep_ident[0] : '0;
          k   = 0;
          // slide smaller entries down; new pair sits below the first equal or larger one
          while (k + 1 < LIST_SIZE && keep_score[k+1] < val) begin
            keep_score[k] = keep_score[k+1];
            keep_ident[k] = keep_ident[k+1];
            keep_used[k]  = keep_used[k+1];
            k++;
          end
          keep_score[k] = val;
          keep_ident[k] = id;
          keep_used[k]  = 1'b1;
          awaited_results.push_back(make_result(dv, did, keep_score[0] > finish_limit,
                                                1'b0, '0, '0, 1'b1));
        end else begin
          awaited_results.push_back(make_result(1'b1, id, 1'b0, 1'b0, '0, '0, 1'b1));
        end
      end
      MODE_DRAIN: begin
        held = 0;
        for (int i = 0; i < LIST_SIZE; i++)
          if (keep_used[i]) held++;
        if (held > MAX_RESULTS) held = MAX_RESULTS;
        if (held == 0) begin
          awaited_results.push_back(make_result(1'b0, '0, 1'b0, 1'b0, '0, '0, 1'b1));
        end else begin
          n = 0;
          for (int i = LIST_SIZE - 1; i >= 0 && n < held; i--) begin
            if (keep_used[i]) begin
              awaited_results.push_back(make_result(1'b0, '0, 1'b0, 1'b1, keep_score[i],
                                                    keep_ident[i], n == held - 1));
              keep_used[i] = 1'b0;
              n++;
            end
          end
        end
      end
      MODE_CLEAR: clear_slots();
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  task automatic check_result(input keep_result_t got);
    keep_result_t want;
    results_seen++;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing pending: %h",
                                results_seen, got));
      return;
    end
    want = awaited_results.pop_front();
    compare_field("dropped_valid", got.dropped_valid, want.dropped_valid);
    compare_field("dropped_id",    got.dropped_id,    want.dropped_id);
    compare_field("finish",        got.finish,        want.finish);
    compare_field("entry_valid",   got.entry_valid,   want.entry_valid);
    compare_field("entry_value",   got.entry_value,   want.entry_value);
    compare_field("entry_id",      got.entry_id,      want.entry_id);
    compare_field("last",          got.last,          want.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_slots();
      finish_limit = 32'sh7FFFFFFF;
      awaited_results.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) finish_limit = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        apply_keep_best(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[47:32]);
      if (m_axis_tvalid && m_axis_tready)
        check_result(make_result(m_axis_tuser[0], m_axis_tdata[15:0], m_axis_tdata[16],
                                 m_axis_tuser[1], m_axis_tdata[48:17], m_axis_tdata[64:49],
                                 m_axis_tlast));
    end
    fail_count <= mismatches;
    pending    <= awaited_results.size();
    checked    <= results_seen;
  end

endmodule

/* test/top_k_sorted_keep_best_unit_tb.sv */
// Testbench top for top_k_sorted_keep_best_unit: clock, reset, stimulus and verdict.
// Prediction and comparison live in top_k_sorted_keep_best_checker.
// Depends on tksk_pkg, the unit RTL and the checker.
module top_k_sorted_keep_best_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tksk_pkg::*;

  localparam int         LIST_SIZE       = 16;
  localparam logic [1:0] MODE_IGNORED    = 2'd3;
  localparam int         ITEMS_PER_PHASE = 68;
  localparam int         HOLD_CYCLES     = 80;
  localparam int         SETTLE_CYCLES   = LIST_SIZE + 4;
  localparam int         QUIET_LIMIT     = 2000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [31:0]            cfg_wdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  int   fail_count;
  int   pending;
  int   checked;
  int   items_sent = 0;
  int   send_idle_pct = 35;
  int   recv_idle_pct = 47;
  int   quiet_cycles = 0;
  logic hold_go = 1'b0;
  logic hold_rx = 1'b0;

  always #5 clk = ~clk;

  top_k_sorted_keep_best_unit #(
    .LIST_SIZE(LIST_SIZE),
    .ID_WIDTH (16)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  top_k_sorted_keep_best_checker #(
    .LIST_SIZE(LIST_SIZE)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  always @(posedge clk) begin
    if (rst || hold_rx)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off so the output register backs up into the input
  initial begin
    while (!hold_go) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic signed [31:0] val,
                           input logic [15:0] id);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3) + 1) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {id, val};
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (mode != MODE_IGNORED) items_sent++;
  endtask

  task automatic settle_outputs();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] limit);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_score();
    int g;
    case ($urandom_range(9))
      0, 1: return $urandom;
      2, 3, 4, 5: begin
        // coarse grid so equal scores show up often
        g = int'($urandom_range(16)) - 8;
        return g * 65536;
      end
      6, 7: return int'($urandom_range(32'h7FFFF)) - 32'sh40000;
      8: begin
        case ($urandom_range(4))
          0:       return 32'sh80000000;
          1:       return 32'sh7FFFFFFF;
          2:       return 32'sh0;
          3:       return -32'sh1;
          default: return 32'sh1;
        endcase
      end
      default: return int'($urandom_range(32'h7FFF)) <<< 16;
    endcase
  endfunction

  task automatic run_random_phase(input int count);
    int done;
    int r;
    logic [1:0] mode;
    done = 0;
    while (done < count) begin
      r = $urandom_range(99);
      if (r < 80)      mode = MODE_INSERT;
      else if (r < 90) mode = MODE_DRAIN;
      else if (r < 94) mode = MODE_CLEAR;
      else             mode = MODE_IGNORED;
      send_item(mode, pick_score(), 16'($urandom_range(16'hFFFF)));
      if (mode != MODE_IGNORED) done++;
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_INSERT;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_threshold(32'sh0);

    // directed list
    send_item(MODE_DRAIN,  32'sh0,        16'h0000);  // empty drain
    send_item(MODE_INSERT, 32'sh0,        16'h0001);  // equal to slot 0, rejected
    send_item(MODE_INSERT, 32'sh80000000, 16'hFFFF);  // most negative, rejected
    send_item(MODE_INSERT, 32'sh7FFFFFFF, 16'hFFFF);  // evicts an unused slot 0
    send_item(MODE_INSERT, 32'sh10000,    16'h1234);
    send_item(MODE_INSERT, 32'sh1,        16'h5678);
    send_item(MODE_IGNORED, 32'shFFFFFFFF, 16'hFFFF);
    send_item(MODE_DRAIN,  32'shFFFFFFFF, 16'hFFFF);
    send_item(MODE_INSERT, 32'sh20000,    16'h0003);  // drained scores still compare
    send_item(MODE_CLEAR,  32'shFFFFFFFF, 16'hFFFF);
    for (int i = 1; i <= 17; i++)
      send_item(MODE_INSERT, ((i + 1) / 2) * 65536, 16'h1000 + 16'(i));
    send_item(MODE_DRAIN,  32'sh0,        16'h0000);  // full list out

    settle_outputs();
    write_threshold(32'sh80000000);
    run_random_phase(ITEMS_PER_PHASE);

    settle_outputs();
    send_idle_pct = 47;
    recv_idle_pct <= 35;
    write_threshold((int'($urandom_range(8)) - 4) * 65536);
    run_random_phase(ITEMS_PER_PHASE);

    settle_outputs();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_threshold(32'sh7FFFFFFF);
    hold_go <= 1'b1;
    run_random_phase(ITEMS_PER_PHASE);

    settle_outputs();
    $display("Sent %0d transactions (directed list plus three random phases), %0d results checked.",
             items_sent, checked);
    $display("Four finish thresholds used, including both extremes, plus a %0d-cycle output stall.",
             HOLD_CYCLES);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
